// File: hw/rtl/ttt_pkg.sv
// ----------------------------------------------------------------------------
// ttt_pkg: shared types and codes of the two-tier transposition table
// opcodes, the command beat between front and back, and the result beat
// ----------------------------------------------------------------------------
`default_nettype none

package ttt_pkg;

  localparam logic [2:0] OP_STORE     = 3'd0;
  localparam logic [2:0] OP_PROBE_CUR = 3'd1;
  localparam logic [2:0] OP_PROBE_ANY = 3'd2;
  localparam logic [2:0] OP_NEW_TURN  = 3'd3;
  localparam logic [2:0] OP_HIST      = 3'd4;

  localparam int          NUM_BINS  = 64;
  localparam logic [11:0] COUNT_MAX = 12'd4095;

  typedef struct packed {
    logic [2:0]         op;
    logic [63:0]        key;
    logic [15:0]        move;
    logic [5:0]         depth;
    logic signed [31:0] score;
    logic [1:0]         kind;
    logic [6:0]         limit;
  } cmd_t;

  typedef struct packed {
    logic               hit;
    logic [15:0]        found_move;
    logic [5:0]         found_depth;
    logic signed [31:0] found_score;
    logic [1:0]         found_kind;
    logic [5:0]         bin;
    logic [11:0]        bin_count;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/ttt_ram.sv
// ----------------------------------------------------------------------------
// ttt_ram: generic single-write, single-read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ttt_fifo.sv
// ----------------------------------------------------------------------------
// ttt_fifo: small register queue
// decouples producer and consumer, push only while not full
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ttt_front.sv
// ----------------------------------------------------------------------------
// ttt_front: input stage of the table unit
// takes one item, reduces its hash to a slot index, hands it to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_front import ttt_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int INDEX_MASK    = 1023,
  parameter int IDX_W         = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_push_i,
  input  wire cmd_t             in_cmd_i,
  output logic                  in_full_o,
  output logic                  q_push_o,
  output cmd_t                  q_cmd_o,
  output logic      [IDX_W-1:0] q_idx_o,
  input  wire logic             q_full_i
);

  localparam int  MASK_W = (INDEX_MASK > 0) ? $clog2(INDEX_MASK + 1) : 1;
  localparam int  VW     = ((MASK_W > IDX_W) ? MASK_W : IDX_W) + 1;
  localparam bit  POW2   = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
  localparam int  STEPS  = POW2 ? 0 : ((MASK_W >= IDX_W) ? (MASK_W - IDX_W + 1) : 1);
  localparam int  SW     = (STEPS > 0) ? $clog2(STEPS + 1) : 1;

  logic          busy_q, busy_d;
  logic [SW-1:0] step_q, step_d;
  logic [VW-1:0] val_q, val_d;
  logic [VW-1:0] masked, sub;
  cmd_t          cmd_q, cmd_d;
  logic          accept;

  assign masked    = VW'(in_cmd_i.key[MASK_W-1:0] & MASK_W'(INDEX_MASK));
  assign q_push_o  = busy_q && (step_q == '0) && !q_full_i;
  assign in_full_o = busy_q && !q_push_o;
  assign accept    = in_push_i && !in_full_o;
  assign q_cmd_o   = cmd_q;
  assign q_idx_o   = val_q[IDX_W-1:0];
  assign sub       = VW'(TABLE_ENTRIES) << (step_q - SW'(1));

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    val_d  = val_q;
    cmd_d  = cmd_q;
    priority if (accept) begin
      busy_d = 1'b1;
      step_d = SW'(STEPS);
      val_d  = masked;
      cmd_d  = in_cmd_i;
    end else if (busy_q && step_q != '0) begin
      // one conditional subtract of the shifted table size per cycle
      step_d = step_q - SW'(1);
      if (val_q >= sub) begin
        val_d = val_q - sub;
      end
    end else if (q_push_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    cmd_q <= cmd_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/ttt_back.sv
// ----------------------------------------------------------------------------
// ttt_back: execution stage of the table unit
// clear pass, store and probe over both tiers, generation, depth histogram
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_back import ttt_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int MOVE_BITS     = 16,
  parameter int IDX_W         = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  input  wire cmd_t             q_cmd_i,
  input  wire logic [IDX_W-1:0] q_idx_i,
  output logic                  q_pop_o,
  input  wire logic             res_pop_i,
  output res_t                  res_o,
  output logic                  res_empty_o
);

  localparam int MW       = (MOVE_BITS < 16) ? MOVE_BITS : 16;
  localparam int EW       = 1 + 16 + 6 + 2 + MW + 32 + 64;
  localparam int SCORE_LO = 64;
  localparam int MOVE_LO  = 96;
  localparam int KIND_LO  = MOVE_LO + MW;
  localparam int DEPTH_LO = KIND_LO + 2;
  localparam int GEN_LO   = DEPTH_LO + 6;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_LOOK   = 3'd2;
  localparam logic [2:0] ST_HSCAN  = 3'd3;
  localparam logic [2:0] ST_HDRAIN = 3'd4;
  localparam logic [2:0] ST_HOUT   = 3'd5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [15:0]      gen_q, gen_d;
  logic             scan_vld_q;
  logic [6:0]       k_q, k_d, lim_q, lim_d;
  cmd_t             cur_q, cur_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [11:0]      cnt_q [NUM_BINS];
  logic [11:0]      cnt_d [NUM_BINS];

  logic             re, we_deep, we_spare;
  logic [IDX_W-1:0] raddr, waddr;
  logic [EW-1:0]    wdata, new_entry, deep_rd, spare_rd;
  logic             cnt_clr, cnt_shift;
  logic             res_push, res_full;
  res_t             res_d;

  logic             d_match, s_match, d_cur, s_cur, need_cur;
  logic [EW-1:0]    hit_rd;
  logic [6:0]       lim_clamp;

  ttt_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_deep (
    .clk_i   (clk_i),
    .we_i    (we_deep),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (deep_rd)
  );

  ttt_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_spare (
    .clk_i   (clk_i),
    .we_i    (we_spare),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (spare_rd)
  );

  ttt_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_d),
    .full_o  (res_full),
    .pop_i   (res_pop_i),
    .data_o  (res_o),
    .empty_o (res_empty_o)
  );

  assign new_entry = {1'b1, gen_q, cur_q.depth, cur_q.kind, cur_q.move[MW-1:0],
                      cur_q.score, cur_q.key};

  // slot classification from the registered read data
  assign d_cur    = deep_rd[EW-1] && (deep_rd[GEN_LO +: 16] == gen_q);
  assign s_cur    = spare_rd[EW-1] && (spare_rd[GEN_LO +: 16] == gen_q);
  assign need_cur = (cur_q.op == OP_PROBE_CUR);
  assign d_match  = deep_rd[EW-1] && (deep_rd[63:0] == cur_q.key) && (!need_cur || d_cur);
  assign s_match  = spare_rd[EW-1] && (spare_rd[63:0] == cur_q.key) && (!need_cur || s_cur);
  assign hit_rd   = d_match ? deep_rd : spare_rd;

  always_comb begin
    priority if (q_cmd_i.limit == 7'd0) begin
      lim_clamp = 7'd1;
    end else if (q_cmd_i.limit > 7'd64) begin
      lim_clamp = 7'd64;
    end else begin
      lim_clamp = q_cmd_i.limit;
    end
  end

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    gen_d     = gen_q;
    k_d       = k_q;
    lim_d     = lim_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    re        = 1'b0;
    raddr     = q_idx_i;
    we_deep   = 1'b0;
    we_spare  = 1'b0;
    waddr     = idx_q;
    wdata     = new_entry;
    q_pop_o   = 1'b0;
    res_push  = 1'b0;
    res_d     = '0;
    cnt_clr   = 1'b0;
    cnt_shift = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        we_deep  = 1'b1;
        we_spare = 1'b1;
        waddr    = ptr_q;
        wdata    = '0;
        ptr_d    = ptr_q + IDX_W'(1);
        if (ptr_q == LAST_IDX) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_cmd_i;
          idx_d   = q_idx_i;
          unique case (q_cmd_i.op)
            OP_STORE, OP_PROBE_CUR, OP_PROBE_ANY: begin
              re      = 1'b1;
              state_d = ST_LOOK;
            end
            OP_NEW_TURN: begin
              gen_d = gen_q + 16'd1;
            end
            OP_HIST: begin
              cnt_clr = 1'b1;
              ptr_d   = '0;
              k_d     = '0;
              lim_d   = lim_clamp;
              state_d = ST_HSCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOK: begin
        if (cur_q.op == OP_STORE) begin
          if (deep_rd[DEPTH_LO +: 6] <= cur_q.depth || deep_rd[GEN_LO +: 16] != gen_q) begin
            we_deep = 1'b1;
          end else begin
            we_spare = 1'b1;
          end
          state_d = ST_IDLE;
        end else if (!res_full) begin
          res_push = 1'b1;
          if (d_match || s_match) begin
            res_d.hit         = 1'b1;
            res_d.found_move  = 16'(hit_rd[MOVE_LO +: MW]);
            res_d.found_depth = hit_rd[DEPTH_LO +: 6];
            res_d.found_score = hit_rd[SCORE_LO +: 32];
            res_d.found_kind  = hit_rd[KIND_LO +: 2];
          end
          state_d = ST_IDLE;
        end
      end
      ST_HSCAN: begin
        re    = 1'b1;
        raddr = ptr_q;
        ptr_d = ptr_q + IDX_W'(1);
        if (ptr_q == LAST_IDX) begin
          ptr_d   = '0;
          state_d = ST_HDRAIN;
        end
      end
      ST_HDRAIN: begin
        state_d = ST_HOUT;
      end
      ST_HOUT: begin
        res_d.bin       = k_q[5:0];
        res_d.bin_count = cnt_q[0];
        res_d.last      = (k_q + 7'd1 == lim_q);
        if (!res_full) begin
          res_push  = 1'b1;
          cnt_shift = 1'b1;
          k_d       = k_q + 7'd1;
          if (k_q + 7'd1 == lim_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // one counter lane per depth bin, shifted toward bin zero while reporting
  always_comb begin
    logic [1:0]  inc;
    logic [12:0] sum;
    for (int j = 0; j < NUM_BINS; j++) begin
      inc = 2'((d_cur && deep_rd[DEPTH_LO +: 6] == 6'(j)))
          + 2'((s_cur && spare_rd[DEPTH_LO +: 6] == 6'(j)));
      sum = {1'b0, cnt_q[j]} + 13'(inc);
      priority if (cnt_clr) begin
        cnt_d[j] = '0;
      end else if (scan_vld_q) begin
        cnt_d[j] = (sum > 13'(COUNT_MAX)) ? COUNT_MAX : sum[11:0];
      end else if (cnt_shift) begin
        cnt_d[j] = (j == NUM_BINS - 1) ? 12'd0 : cnt_q[(j + 1) % NUM_BINS];
      end else begin
        cnt_d[j] = cnt_q[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      ptr_q      <= '0;
      gen_q      <= '0;
      scan_vld_q <= 1'b0;
      k_q        <= '0;
      lim_q      <= 7'd1;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      gen_q      <= gen_d;
      scan_vld_q <= (state_q == ST_HSCAN);
      k_q        <= k_d;
      lim_q      <= lim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    idx_q <= idx_d;
    for (int j = 0; j < NUM_BINS; j++) begin
      cnt_q[j] <= cnt_d[j];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/two_tier_transposition_table_unit.sv
// ----------------------------------------------------------------------------
// two_tier_transposition_table_unit: depth-preferred / always-replace table
// hash-indexed two-tier search table with a generation counter and histogram
// ----------------------------------------------------------------------------
// store and probe in the back stage: ram read, then compare and write or result push
// new turn: generation step; histogram: scan over every slot, then one beat per bin
// a table size that is not a power of two holds each item in the front while its
// index is reduced by conditional subtracts of the shifted table size
// probe path: front register, command queue, ram read, result queue, then the ports
// reset: asynchronous; after release a clearing pass over all TABLE_ENTRIES slots zeroes
// both tiers, items are queued but not executed until it ends
`default_nettype none

module two_tier_transposition_table_unit import ttt_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int INDEX_MASK    = 1023,
  parameter int MOVE_BITS     = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // item side
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         op_i,
  input  wire logic [63:0]        key_i,
  input  wire logic [15:0]        best_move_i,
  input  wire logic [5:0]         search_depth_i,
  input  wire logic signed [31:0] score_i,
  input  wire logic [1:0]         node_kind_i,
  input  wire logic [6:0]         depth_limit_i,
  // result side
  output logic                    empty,
  input  wire logic               pop,
  output logic                    hit_o,
  output logic      [15:0]        found_move_o,
  output logic      [5:0]         found_depth_o,
  output logic signed [31:0]      found_score_o,
  output logic      [1:0]         found_kind_o,
  output logic      [5:0]         bin_o,
  output logic      [11:0]        bin_count_o,
  output logic                    last_o
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int QW    = $bits(cmd_t) + IDX_W;

  cmd_t             in_cmd, f_cmd, b_cmd;
  logic [IDX_W-1:0] f_idx, b_idx;
  logic             f_push, q_full, q_empty, b_pop;
  res_t             res;

  // gather the item beat into one command word
  assign in_cmd.op    = op_i;
  assign in_cmd.key   = key_i;
  assign in_cmd.move  = best_move_i;
  assign in_cmd.depth = search_depth_i;
  assign in_cmd.score = score_i;
  assign in_cmd.kind  = node_kind_i;
  assign in_cmd.limit = depth_limit_i;

  // front: accept and compute the slot index
  ttt_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .INDEX_MASK    (INDEX_MASK),
    .IDX_W         (IDX_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_push_i (push),
    .in_cmd_i  (in_cmd),
    .in_full_o (full),
    .q_push_o  (f_push),
    .q_cmd_o   (f_cmd),
    .q_idx_o   (f_idx),
    .q_full_i  (q_full)
  );

  // two-entry command queue between front and back
  ttt_fifo #(.WIDTH(QW), .DEPTH(2)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  ({f_cmd, f_idx}),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .data_o  ({b_cmd, b_idx}),
    .empty_o (q_empty)
  );

  // back: table rams, generation, histogram and result queue
  ttt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MOVE_BITS     (MOVE_BITS),
    .IDX_W         (IDX_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (b_cmd),
    .q_idx_i     (b_idx),
    .q_pop_o     (b_pop),
    .res_pop_i   (pop),
    .res_o       (res),
    .res_empty_o (empty)
  );

  // result beat onto its ports
  assign hit_o         = res.hit;
  assign found_move_o  = res.found_move;
  assign found_depth_o = res.found_depth;
  assign found_score_o = res.found_score;
  assign found_kind_o  = res.found_kind;
  assign bin_o         = res.bin;
  assign bin_count_o   = res.bin_count;
  assign last_o        = res.last;

endmodule

`default_nettype wire

// File: hw/rtl/ttt_checker.sv
// ----------------------------------------------------------------------------
// ttt_checker: port-level checks of the table unit
// result queue behavior and result beat consistency
// ----------------------------------------------------------------------------
`default_nettype none

module ttt_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic               hit_o,
  input wire logic [15:0]        found_move_o,
  input wire logic [5:0]         found_depth_o,
  input wire logic signed [31:0] found_score_o,
  input wire logic [1:0]         found_kind_o,
  input wire logic [5:0]         bin_o,
  input wire logic [11:0]        bin_count_o,
  input wire logic               last_o
);

  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result queue not empty during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(hit_o) && $stable(found_score_o)
                          && $stable(bin_o) && $stable(bin_count_o) && $stable(last_o)))
    else $error("waiting result beat changed");

  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && hit_o) |-> (bin_o == 6'd0 && bin_count_o == 12'd0 && !last_o))
    else $error("probe hit carries histogram fields");

  a_miss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !hit_o) |-> (found_move_o == 16'd0 && found_depth_o == 6'd0
                            && found_score_o == 32'sd0 && found_kind_o == 2'd0))
    else $error("result without hit carries entry fields");

endmodule

bind two_tier_transposition_table_unit ttt_checker u_ttt_checker (.*);

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the two-tier transposition table unit
// directed table of stores, probes, new turns and histograms, then random
// traffic on a handful of slots, all checked against an in-bench table model
// ----------------------------------------------------------------------------
`default_nettype none

module tb import ttt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES    = 1024;
  localparam int IDX_MASK   = 1023;
  localparam int LIMIT_CYC  = 2000000;

  // one stimulus row; chk set means exp holds a typed-in result for a probe
  typedef struct {
    cmd_t cmd;
    bit   chk;
    res_t exp;
  } row_t;

  logic clk, rst_n;
  logic push, full, empty, pop;
  logic [2:0]         op;
  logic [63:0]        key;
  logic [15:0]        move;
  logic [5:0]         depth;
  logic signed [31:0] score;
  logic [1:0]         kind;
  logic [6:0]         limit;
  res_t got;

  two_tier_transposition_table_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .push(push), .full(full),
    .op_i(op), .key_i(key), .best_move_i(move), .search_depth_i(depth),
    .score_i(score), .node_kind_i(kind), .depth_limit_i(limit),
    .empty(empty), .pop(pop),
    .hit_o(got.hit), .found_move_o(got.found_move), .found_depth_o(got.found_depth),
    .found_score_o(got.found_score), .found_kind_o(got.found_kind),
    .bin_o(got.bin), .bin_count_o(got.bin_count), .last_o(got.last)
  );

  // table model state
  typedef struct packed {
    logic               valid;
    logic [15:0]        gen;
    logic [5:0]         depth;
    logic [1:0]         kind;
    logic [15:0]        move;
    logic [63:0]        key;
    logic signed [31:0] score;
  } slot_t;

  slot_t       deep_tier[ENTRIES];
  slot_t       spare_tier[ENTRIES];
  logic [15:0] cur_gen;
  res_t        pending_results[$];
  int          errors;
  bit          no_idle;      // last part of the run: no gaps on either side
  bit          hold_results; // long receiver hold-off

  function automatic bit slot_hits(slot_t s, logic [63:0] k, bit need_cur);
    return s.valid && s.key == k && (!need_cur || s.gen == cur_gen);
  endfunction

  // apply one beat to the model and queue the results it causes
  task automatic table_apply(cmd_t c);
    int   idx;
    int   lim;
    int   counts[64];
    slot_t w, hit_slot;
    res_t r;
    bit   hit;
    idx = int'(c.key & IDX_MASK) % ENTRIES;
    case (c.op)
      OP_STORE: begin
        w = '{1'b1, cur_gen, c.depth, c.kind, c.move, c.key, c.score};
        if (deep_tier[idx].depth <= c.depth || deep_tier[idx].gen != cur_gen) begin
          deep_tier[idx] = w;
        end else begin
          spare_tier[idx] = w;
        end
      end
      OP_PROBE_CUR, OP_PROBE_ANY: begin
        r = '0;
        hit = 1'b1;
        if (slot_hits(deep_tier[idx], c.key, c.op == OP_PROBE_CUR)) begin
          hit_slot = deep_tier[idx];
        end else if (slot_hits(spare_tier[idx], c.key, c.op == OP_PROBE_CUR)) begin
          hit_slot = spare_tier[idx];
        end else begin
          hit = 1'b0;
        end
        if (hit) begin
          r.hit = 1'b1;
          r.found_move = hit_slot.move;
          r.found_depth = hit_slot.depth;
          r.found_score = hit_slot.score;
          r.found_kind = hit_slot.kind;
        end
        pending_results.push_back(r);
      end
      OP_NEW_TURN: cur_gen = cur_gen + 16'd1;
      OP_HIST: begin
        lim = c.limit;
        if (lim < 1) lim = 1;
        if (lim > 64) lim = 64;
        foreach (counts[i]) counts[i] = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (deep_tier[i].valid && deep_tier[i].gen == cur_gen &&
              deep_tier[i].depth < lim && counts[deep_tier[i].depth] < 4095)
            counts[deep_tier[i].depth]++;
          if (spare_tier[i].valid && spare_tier[i].gen == cur_gen &&
              spare_tier[i].depth < lim && counts[spare_tier[i].depth] < 4095)
            counts[spare_tier[i].depth]++;
        end
        for (int k = 0; k < lim; k++) begin
          r = '0;
          r.bin = 6'(k);
          r.bin_count = 12'(counts[k]);
          r.last = (k + 1 == lim);
          pending_results.push_back(r);
        end
      end
      default: ; // unused opcodes are ignored
    endcase
  endtask

  // clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  int cycles;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    int gap;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_results) begin
        pop <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9);
        pop <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // result checker: compare each popped beat with the oldest expectation
  always @(posedge clk) begin
    res_t e;
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (got.hit !== e.hit) begin
          $error("hit exp %0h got %0h", e.hit, got.hit); errors++;
        end
        if (got.found_move !== e.found_move) begin
          $error("found_move exp %0h got %0h", e.found_move, got.found_move); errors++;
        end
        if (got.found_depth !== e.found_depth) begin
          $error("found_depth exp %0d got %0d", e.found_depth, got.found_depth); errors++;
        end
        if (got.found_score !== e.found_score) begin
          $error("found_score exp %0d got %0d", e.found_score, got.found_score); errors++;
        end
        if (got.found_kind !== e.found_kind) begin
          $error("found_kind exp %0d got %0d", e.found_kind, got.found_kind); errors++;
        end
        if (got.bin !== e.bin) begin
          $error("bin exp %0d got %0d", e.bin, got.bin); errors++;
        end
        if (got.bin_count !== e.bin_count) begin
          $error("bin_count exp %0d got %0d", e.bin_count, got.bin_count); errors++;
        end
        if (got.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, got.last); errors++;
        end
      end
    end
  end

  // send one beat, holding it until accepted
  task automatic send_beat(cmd_t c);
    push  <= 1'b1;
    op    <= c.op;
    key   <= c.key;
    move  <= c.move;
    depth <= c.depth;
    score <= c.score;
    kind  <= c.kind;
    limit <= c.limit;
    do @(posedge clk); while (full);
    table_apply(c);
  endtask

  task automatic sender_gap();
    int gap;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic cmd_t mk(logic [2:0] o, logic [63:0] k, logic [15:0] m,
                              logic [5:0] d, logic [31:0] s, logic [1:0] nk,
                              logic [6:0] l);
    cmd_t c;
    c.op = o; c.key = k; c.move = m; c.depth = d; c.score = s; c.kind = nk;
    c.limit = l;
    return c;
  endfunction

  function automatic res_t hit_res(logic [15:0] m, logic [5:0] d, logic [31:0] s,
                                   logic [1:0] nk);
    res_t r;
    r = '0;
    r.hit = 1'b1; r.found_move = m; r.found_depth = d; r.found_score = s;
    r.found_kind = nk;
    return r;
  endfunction

  // random item on a few slots so that stores and probes collide
  function automatic cmd_t rand_cmd(logic [63:0] keys[8]);
    cmd_t c;
    int   pick;
    c.key   = keys[$urandom_range(0, 7)];
    c.move  = 16'($urandom);
    c.depth = 6'($urandom);
    c.score = $urandom;
    c.kind  = 2'($urandom);
    c.limit = 7'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) c.op = OP_STORE;
    else if (pick < 62) c.op = OP_PROBE_CUR;
    else if (pick < 84) c.op = OP_PROBE_ANY;
    else if (pick < 91) c.op = OP_NEW_TURN;
    else if (pick < 96) c.op = 3'($urandom_range(5, 7));
    else c.op = OP_HIST;
    // histograms mostly short, so the run stays quick
    if (c.op == OP_HIST && $urandom_range(0, 3) != 0) c.limit = 7'($urandom_range(0, 8));
    if ($urandom_range(0, 9) == 0) c.key = {$urandom, $urandom};
    return c;
  endfunction

  row_t        dir_rows[$];
  logic [63:0] key_pool[8];

  initial begin
    cmd_t c;
    res_t none;
    errors = 0; cycles = 0; no_idle = 0; hold_results = 0;
    cur_gen = '0;
    foreach (deep_tier[i]) begin
      deep_tier[i] = '0;
      spare_tier[i] = '0;
    end
    none = '0;
    rst_n = 1'b0; push = 1'b0; op = OP_STORE; key = '0; move = '0; depth = '0;
    score = '0; kind = '0; limit = 7'd1;

    // directed rows: extremes, both tiers, generations, odd opcodes, limits
    dir_rows = '{
      '{mk(OP_PROBE_ANY, 64'd0, 0, 0, 0, 0, 0), 1, none},
      '{mk(OP_HIST, 64'd0, 0, 0, 0, 0, 7'd0), 0, none},
      '{mk(OP_STORE, 64'd0, 16'hffff, 6'd63, 32'h7fffffff, 2'd3, 0), 0, none},
      '{mk(OP_PROBE_CUR, 64'd0, 0, 0, 0, 0, 0), 1,
        hit_res(16'hffff, 6'd63, 32'h7fffffff, 2'd3)},
      '{mk(OP_STORE, 64'hffffffffffffffff, 16'h0, 6'd0, 32'h80000000, 2'd2, 0), 0, none},
      '{mk(OP_STORE, 64'hfffffffffffffc00 | 64'h3ff, 16'h1234, 6'd0, 32'h1, 2'd1, 0),
        0, none},
      '{mk(OP_STORE, 64'h00000000000003ff, 16'h5555, 6'd10, 32'hfffe0000, 2'd0, 0), 0, none},
      '{mk(OP_STORE, 64'h00000000000007ff, 16'haaaa, 6'd5, 32'h00010000, 2'd1, 0), 0, none},
      '{mk(OP_PROBE_CUR, 64'h00000000000007ff, 0, 0, 0, 0, 0), 1,
        hit_res(16'haaaa, 6'd5, 32'h00010000, 2'd1)},
      '{mk(OP_PROBE_ANY, 64'h00000000000003ff, 0, 0, 0, 0, 0), 1,
        hit_res(16'h5555, 6'd10, 32'hfffe0000, 2'd0)},
      '{mk(OP_PROBE_ANY, 64'h1234567800000001, 0, 0, 0, 0, 0), 1, none},
      '{mk(3'd5, 64'd1, 0, 0, 0, 0, 0), 0, none},
      '{mk(3'd6, 64'd1, 0, 0, 0, 0, 0), 0, none},
      '{mk(3'd7, 64'd1, 0, 0, 0, 0, 0), 0, none},
      '{mk(OP_HIST, 64'd0, 0, 0, 0, 0, 7'd64), 0, none},
      '{mk(OP_NEW_TURN, 64'd0, 0, 0, 0, 0, 0), 0, none},
      '{mk(OP_PROBE_CUR, 64'd0, 0, 0, 0, 0, 0), 1, none},
      '{mk(OP_PROBE_ANY, 64'd0, 0, 0, 0, 0, 0), 1,
        hit_res(16'hffff, 6'd63, 32'h7fffffff, 2'd3)},
      '{mk(OP_STORE, 64'h00000000000003ff, 16'h0f0f, 6'd1, 32'h0, 2'd2, 0), 0, none},
      '{mk(OP_PROBE_CUR, 64'h00000000000003ff, 0, 0, 0, 0, 0), 1,
        hit_res(16'h0f0f, 6'd1, 32'h0, 2'd2)},
      '{mk(OP_HIST, 64'd0, 0, 0, 0, 0, 7'd127), 0, none},
      '{mk(OP_HIST, 64'd0, 0, 0, 0, 0, 7'd3), 0, none}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].cmd);
      // typed-in value must agree with the table model for that probe
      if (dir_rows[i].chk && pending_results[$] !== dir_rows[i].exp) begin
        $error("directed row %0d: typed result %p, model %p",
               i, dir_rows[i].exp, pending_results[$]);
        errors++;
      end
      sender_gap();
    end

    // sender pause until all results are in
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[1] = key_pool[0] ^ 64'h400;          // same slot, different key
    key_pool[2] = key_pool[0] ^ 64'h8000000000000000;

    // receiver hold-off while the sender keeps pushing probes
    hold_results = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_results = 0;
      end
      for (int n = 0; n < 40; n++) begin
        c = rand_cmd(key_pool);
        c.op = OP_PROBE_ANY;
        send_beat(c);
      end
    join

    for (int n = 0; n < 100; n++) begin
      if (n == 75) no_idle = 1;
      if (n == 40) foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      send_beat(rand_cmd(key_pool));
      sender_gap();
    end
    push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
